/* hdl/ttb_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the triangle tangent basis block
package ttb_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 2;

    // multiplier operand, product, accumulator, divider and square root widths
    localparam int OPW   = WORD_BITS + 1;
    localparam int PRODW = 2 * OPW;
    localparam int ACCW  = 2 * WORD_BITS + 3;
    localparam int NUMW  = ACCW + FRAC_BITS;
    localparam int DENW  = ACCW;
    localparam int SQW   = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [OPW-1:0]       t_opnd;
    typedef logic signed [ACCW-1:0]      t_acc;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word tex_u;
        t_word tex_v;
        t_word norm_x;
        t_word norm_y;
        t_word norm_z;
    } t_in;

    typedef struct packed {
        t_word tan_x;
        t_word tan_y;
        t_word tan_z;
        t_word bitan_x;
        t_word bitan_y;
        t_word bitan_z;
        logic  degenerate;
        logic  last_of_triangle;
    } t_out;

    typedef struct packed {
        t_in v0;
        t_in v1;
        t_in v2;
    } t_tri;

    typedef struct packed {
        logic [NUMW-1:0] num;
        logic [DENW-1:0] den;
        logic            neg;
    } t_div_req;

    function automatic t_opnd ext_opnd(input t_word w);
        return {w[WORD_BITS-1], w};
    endfunction

    function automatic t_acc ext_acc(input t_word w);
        return {{(ACCW-WORD_BITS){w[WORD_BITS-1]}}, w};
    endfunction

    function automatic logic [ACCW-1:0] mag_acc(input t_acc v);
        return v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    endfunction

    // clamp to the signed word range
    function automatic t_word sat_word(input t_acc v);
        logic [ACCW-WORD_BITS:0] top;
        top = v[ACCW-1:WORD_BITS-1];
        if (top == '0 || top == '1) begin
            return v[WORD_BITS-1:0];
        end
        return v[ACCW-1] ? WORD_MIN : WORD_MAX;
    endfunction

endpackage

/* hdl/ttb_fifo.sv */
`timescale 1ns / 1ps
// triangle queue between the vertex front end and the arithmetic back end
module ttb_fifo #(
    parameter int DEPTH = ttb_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttb_pkg::t_tri i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output ttb_pkg::t_tri o_head_data
);
    import ttb_pkg::*;

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_tri            r_mem [DEPTH];
    logic [PTRW-1:0] r_wr;
    logic [PTRW-1:0] r_rd;
    logic [CNTW-1:0] r_cnt;

    assign o_full       = (r_cnt == CNTW'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/ttb_front.sv */
`timescale 1ns / 1ps
// vertex front end: holds the first two vertices and queues whole triangles
module ttb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ttb_pkg::t_in  i_in_data,
    input  logic          i_full,
    output logic          o_push,
    output ttb_pkg::t_tri o_push_data
);
    import ttb_pkg::*;

    logic [1:0] r_phase;
    t_in        r_v0;
    t_in        r_v1;
    logic       accept;
    logic       third;

    // phase three never occurs but is handled as a third vertex
    assign third       = r_phase[1];
    assign o_in_ready  = !third || !i_full;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept && third;
    assign o_push_data = '{v0: r_v0, v1: r_v1, v2: i_in_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept) begin
            if (third) begin
                r_phase <= '0;
            end else begin
                r_phase <= r_phase + 1'b1;
                if (r_phase[0]) begin
                    r_v1 <= i_in_data;
                end else begin
                    r_v0 <= i_in_data;
                end
            end
        end
    end

endmodule

/* hdl/ttb_div.sv */
`timescale 1ns / 1ps
// bit-serial restoring divider with a saturated signed word quotient
module ttb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ttb_pkg::t_div_req i_req,
    output logic              o_done,
    output ttb_pkg::t_word    o_quo
);
    import ttb_pkg::*;

    localparam int CW = $clog2(NUMW + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [NUMW-1:0]      r_num;
    logic [DENW-1:0]      r_den;
    logic [DENW-1:0]      r_rem;
    logic [WORD_BITS-1:0] r_q;
    logic                 r_ovf;
    logic                 r_neg;
    logic [DENW:0]        rem_sh;
    logic [DENW+1:0]      diff;
    logic                 qbit;

    assign rem_sh = {r_rem, r_num[NUMW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign qbit   = !diff[DENW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUMW);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_num <= {r_num[NUMW-2:0], 1'b0};
                r_rem <= qbit ? diff[DENW-1:0] : rem_sh[DENW-1:0];
                r_q   <= {r_q[WORD_BITS-2:0], qbit};
                r_ovf <= r_ovf | r_q[WORD_BITS-1];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_neg) begin
            if (r_ovf || (r_q[WORD_BITS-1] && |r_q[WORD_BITS-2:0])) begin
                o_quo = WORD_MIN;
            end else begin
                o_quo = -$signed(r_q);
            end
        end else begin
            o_quo = (r_ovf || r_q[WORD_BITS-1]) ? WORD_MAX : $signed(r_q);
        end
    end

endmodule

/* hdl/ttb_sqrt.sv */
`timescale 1ns / 1ps
// digit-by-digit integer square root, two radicand bits per cycle
module ttb_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ttb_pkg::SQW-1:0]      i_x,
    output logic                         o_done,
    output logic [ttb_pkg::WORD_BITS-1:0] o_root
);
    import ttb_pkg::*;

    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [SQW-1:0]       r_x;
    logic [WORD_BITS:0]   r_rem;
    logic [WORD_BITS-1:0] r_root;
    logic [WORD_BITS+2:0] rem_sh;
    logic [WORD_BITS+2:0] trial;
    logic [WORD_BITS+2:0] diff;
    logic                 fits;

    assign rem_sh = {r_rem, r_x[SQW-1:SQW-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WORD_BITS);
                r_x    <= i_x;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x    <= {r_x[SQW-3:0], 2'b00};
                // remainder can reach twice the root, so it keeps one extra bit
                r_rem  <= fits ? diff[WORD_BITS:0] : rem_sh[WORD_BITS:0];
                r_root <= {r_root[WORD_BITS-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/ttb_back.sv */
`timescale 1ns / 1ps
// arithmetic back end: sequencer around one multiplier, a divider and a square root
module ttb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  ttb_pkg::t_tri i_tri,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ttb_pkg::t_out o_out_data
);
    import ttb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DET   = 4'd1;
    localparam logic [3:0] S_NUMT  = 4'd2;
    localparam logic [3:0] S_DIVT  = 4'd3;
    localparam logic [3:0] S_NUMB  = 4'd4;
    localparam logic [3:0] S_DIVB  = 4'd5;
    localparam logic [3:0] S_NT    = 4'd6;
    localparam logic [3:0] S_UV    = 4'd7;
    localparam logic [3:0] S_USQ   = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_DIVU  = 4'd10;
    localparam logic [3:0] S_CROSS = 4'd11;
    localparam logic [3:0] S_CB    = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;
    localparam logic [3:0] S_EMITZ = 4'd14;

    logic [3:0]            r_state;
    logic                  r_ph;
    logic [1:0]            r_term;
    logic [1:0]            r_idx;
    logic [1:0]            r_k;
    logic                  r_detz;
    logic signed [PRODW-1:0] r_prod;
    t_acc                  r_acc;
    logic [DENW-1:0]       r_detmag;
    logic                  r_detneg;
    t_word                 r_tg [3];
    t_word                 r_bt [3];
    t_word                 r_u  [3];
    t_word                 r_t  [3];
    t_word                 r_c  [3];
    t_word                 r_d;
    logic [WORD_BITS-1:0]  r_len;
    logic                  r_out_valid;
    t_out                  r_out;

    t_word    p0 [3];
    t_word    p1 [3];
    t_word    p2 [3];
    t_word    nk [3];
    t_in      vk;
    t_opnd    dp1 [3];
    t_opnd    dp2 [3];
    t_opnd    du1, dv1, du2, dv2;
    t_opnd    op_a, op_b;
    logic [1:0] nterm;
    logic     mac_state;
    logic     sub_term;
    logic     last_term;
    t_acc     prod_ext;
    t_acc     n_acc;
    logic [1:0] j1, j2;
    logic     div_start;
    t_div_req div_req;
    logic     div_done;
    t_word    div_quo;
    logic     sq_start;
    logic     sq_done;
    logic [WORD_BITS-1:0] sq_root;
    logic     slot_free;
    logic     emit_fire;
    t_acc     u_acc;

    function automatic t_word neg_sat(input t_word w);
        return (w == WORD_MIN) ? WORD_MAX : -w;
    endfunction

    // triangle edges and uv deltas straight from the queue head
    always_comb begin
        p0[0] = i_tri.v0.pos_x; p0[1] = i_tri.v0.pos_y; p0[2] = i_tri.v0.pos_z;
        p1[0] = i_tri.v1.pos_x; p1[1] = i_tri.v1.pos_y; p1[2] = i_tri.v1.pos_z;
        p2[0] = i_tri.v2.pos_x; p2[1] = i_tri.v2.pos_y; p2[2] = i_tri.v2.pos_z;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = ext_opnd(p1[i]) - ext_opnd(p0[i]);
            dp2[i] = ext_opnd(p2[i]) - ext_opnd(p0[i]);
        end
        du1 = ext_opnd(i_tri.v1.tex_u) - ext_opnd(i_tri.v0.tex_u);
        dv1 = ext_opnd(i_tri.v1.tex_v) - ext_opnd(i_tri.v0.tex_v);
        du2 = ext_opnd(i_tri.v2.tex_u) - ext_opnd(i_tri.v0.tex_u);
        dv2 = ext_opnd(i_tri.v2.tex_v) - ext_opnd(i_tri.v0.tex_v);
    end

    always_comb begin
        unique case (r_k)
            2'd0:    vk = i_tri.v0;
            2'd1:    vk = i_tri.v1;
            default: vk = i_tri.v2;
        endcase
        nk[0] = vk.norm_x;
        nk[1] = vk.norm_y;
        nk[2] = vk.norm_z;
    end

    // cyclic neighbours for the cross product component
    always_comb begin
        unique case (r_idx)
            2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
            2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
            default: begin j1 = 2'd0; j2 = 2'd1; end
        endcase
    end

    // multiplier operand select and term count per step
    always_comb begin
        op_a      = '0;
        op_b      = '0;
        nterm     = 2'd1;
        mac_state = 1'b1;
        sub_term  = 1'b0;
        unique case (r_state)
            S_DET: begin
                op_a = (r_term == 2'd0) ? du1 : dv1;
                op_b = (r_term == 2'd0) ? dv2 : du2;
                nterm = 2'd2;
                sub_term = 1'b1;
            end
            S_NUMT: begin
                op_a = (r_term == 2'd0) ? dp1[r_idx] : dp2[r_idx];
                op_b = (r_term == 2'd0) ? dv2 : dv1;
                nterm = 2'd2;
                sub_term = 1'b1;
            end
            S_NUMB: begin
                op_a = (r_term == 2'd0) ? dp2[r_idx] : dp1[r_idx];
                op_b = (r_term == 2'd0) ? du1 : du2;
                nterm = 2'd2;
                sub_term = 1'b1;
            end
            S_NT: begin
                op_a = ext_opnd(nk[r_term]);
                op_b = ext_opnd(r_tg[r_term]);
                nterm = 2'd3;
            end
            S_UV: begin
                op_a = ext_opnd(nk[r_idx]);
                op_b = ext_opnd(r_d);
            end
            S_USQ: begin
                op_a = ext_opnd(r_u[r_term]);
                op_b = ext_opnd(r_u[r_term]);
                nterm = 2'd3;
            end
            S_CROSS: begin
                op_a = ext_opnd((r_term == 2'd0) ? nk[j1] : nk[j2]);
                op_b = ext_opnd((r_term == 2'd0) ? r_t[j2] : r_t[j1]);
                nterm = 2'd2;
                sub_term = 1'b1;
            end
            S_CB: begin
                op_a = ext_opnd(r_c[r_term]);
                op_b = ext_opnd(r_bt[r_term]);
                nterm = 2'd3;
            end
            default: begin
                mac_state = 1'b0;
            end
        endcase
    end

    assign last_term = (r_term == nterm - 2'd1);
    assign prod_ext  = {r_prod[PRODW-1], r_prod};
    assign n_acc     = ((r_term == 2'd0) ? t_acc'(0) : r_acc)
                     + ((sub_term && r_term == 2'd1) ? -prod_ext : prod_ext);

    // divider and square root requests
    assign u_acc     = ext_acc(r_u[r_idx]);
    assign div_start = (r_state == S_DIVT || r_state == S_DIVB || r_state == S_DIVU)
                       && !r_ph;
    assign sq_start  = (r_state == S_SQRT) && !r_ph;

    always_comb begin
        if (r_state == S_DIVU) begin
            div_req.num = {mag_acc(u_acc), {FRAC_BITS{1'b0}}};
            div_req.den = {{(DENW-WORD_BITS){1'b0}}, r_len};
            div_req.neg = r_u[r_idx][WORD_BITS-1];
        end else begin
            div_req.num = {mag_acc(r_acc), {FRAC_BITS{1'b0}}};
            div_req.den = r_detmag;
            div_req.neg = r_acc[ACCW-1] ^ r_detneg;
        end
    end

    ttb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ttb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_acc[SQW-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign emit_fire = (r_state == S_EMIT || r_state == S_EMITZ) && slot_free;
    assign o_pop     = emit_fire && (r_k == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= 1'b0;
            r_term      <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_detz      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !emit_fire) begin
                r_out_valid <= 1'b0;
            end
            if (mac_state) begin
                if (!r_ph) begin
                    r_prod <= op_a * op_b;
                    r_ph   <= 1'b1;
                end else begin
                    r_acc  <= n_acc;
                    r_ph   <= 1'b0;
                    r_term <= last_term ? 2'd0 : r_term + 2'd1;
                    if (last_term) begin
                        unique case (r_state)
                            S_DET: begin
                                if (n_acc == '0) begin
                                    r_detz  <= 1'b1;
                                    r_state <= S_EMITZ;
                                end else begin
                                    r_detmag <= mag_acc(n_acc);
                                    r_detneg <= n_acc[ACCW-1];
                                    r_idx    <= '0;
                                    r_state  <= S_NUMT;
                                end
                            end
                            S_NUMT:  r_state <= S_DIVT;
                            S_NUMB:  r_state <= S_DIVB;
                            S_NT: begin
                                r_d     <= sat_word(n_acc >>> FRAC_BITS);
                                r_idx   <= '0;
                                r_state <= S_UV;
                            end
                            S_UV: begin
                                r_u[r_idx] <= sat_word(ext_acc(r_tg[r_idx])
                                                       - (n_acc >>> FRAC_BITS));
                                r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                                if (r_idx == 2'd2) begin
                                    r_state <= S_USQ;
                                end
                            end
                            S_USQ:   r_state <= S_SQRT;
                            S_CROSS: begin
                                r_c[r_idx] <= sat_word(n_acc >>> FRAC_BITS);
                                r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                                if (r_idx == 2'd2) begin
                                    r_state <= S_CB;
                                end
                            end
                            default: begin
                                // orientation check: flip the tangent on a negative sign
                                if (n_acc[ACCW-1]) begin
                                    for (int i = 0; i < 3; i++) begin
                                        r_t[i] <= neg_sat(r_t[i]);
                                    end
                                end
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_head_valid) begin
                            r_state <= S_DET;
                            r_ph    <= 1'b0;
                            r_term  <= '0;
                            r_idx   <= '0;
                            r_k     <= '0;
                            r_detz  <= 1'b0;
                        end
                    end
                    S_DIVT, S_DIVB, S_DIVU: begin
                        if (!r_ph) begin
                            r_ph <= 1'b1;
                        end else if (div_done) begin
                            r_ph <= 1'b0;
                            if (r_state == S_DIVT) begin
                                r_tg[r_idx] <= div_quo;
                                r_state     <= S_NUMB;
                            end else if (r_state == S_DIVB) begin
                                r_bt[r_idx] <= div_quo;
                                r_idx       <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                                r_state     <= (r_idx == 2'd2) ? S_NT : S_NUMT;
                            end else begin
                                r_t[r_idx] <= div_quo;
                                r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                                r_state    <= (r_idx == 2'd2) ? S_CROSS : S_DIVU;
                            end
                        end
                    end
                    S_SQRT: begin
                        if (!r_ph) begin
                            r_ph <= 1'b1;
                        end else if (sq_done) begin
                            r_ph    <= 1'b0;
                            r_len   <= sq_root;
                            r_idx   <= '0;
                            r_state <= (sq_root == '0) ? S_EMITZ : S_DIVU;
                        end
                    end
                    S_EMIT, S_EMITZ: begin
                        if (slot_free) begin
                            r_out_valid <= 1'b1;
                            if (r_state == S_EMIT) begin
                                r_out <= '{tan_x: r_t[0], tan_y: r_t[1], tan_z: r_t[2],
                                           bitan_x: r_bt[0], bitan_y: r_bt[1],
                                           bitan_z: r_bt[2], degenerate: 1'b0,
                                           last_of_triangle: (r_k == 2'd2)};
                            end else begin
                                r_out <= '{tan_x: '0, tan_y: '0, tan_z: '0,
                                           bitan_x: '0, bitan_y: '0, bitan_z: '0,
                                           degenerate: 1'b1,
                                           last_of_triangle: (r_k == 2'd2)};
                            end
                            if (r_k == 2'd2) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_k     <= r_k + 2'd1;
                                r_state <= r_detz ? S_EMITZ : S_NT;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/triangle_tangent_basis.sv */
`timescale 1ns / 1ps
// top level of the per-triangle tangent and bitangent unit
//
//  channel   direction  handshake                 payload
//  in        request    i_in_valid / o_in_ready   i_in_data  (t_in, one vertex)
//  out       result     o_out_valid / i_out_ready o_out_data (t_out, one per vertex)
//
// - the first two vertices of a triangle are taken without a stall; the third
//   is taken as soon as the triangle queue has room
// - the back end works on one triangle at a time, and its bit-serial divider,
//   shared by all of its divisions, takes most of that time; words are Q16.16,
//   and a zero uv determinant skips straight to three degenerate results
// - synchronous active-low reset empties the queue and returns to the first vertex
// - a stalled result holds in the output register while the back end waits
module triangle_tangent_basis #(
    parameter int QDEPTH = ttb_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ttb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ttb_pkg::t_out o_out_data
);
    import ttb_pkg::*;

    // front end to queue
    logic push;
    t_tri push_data;
    logic full;
    // queue to back end
    logic pop;
    logic head_valid;
    t_tri head_data;

    ttb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // whole triangles wait here so vertex intake runs ahead of the arithmetic
    ttb_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_data  (head_data)
    );

    // back end works on the queue head and pops it after the third result
    ttb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_tri        (head_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

/* hdl/ttb_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the tangent basis unit, bound to the top level
module ttb_props (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ttb_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ttb_pkg::t_out o_out_data
);
    import ttb_pkg::*;

    logic in_seen;
    assign in_seen = i_in_valid && o_in_ready && (i_in_data.pos_x == i_in_data.pos_x);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.tan_x == '0 && o_out_data.tan_y == '0 && o_out_data.tan_z == '0
            && o_out_data.bitan_x == '0 && o_out_data.bitan_y == '0
            && o_out_data.bitan_z == '0)
        else $error("degenerate result carries nonzero vectors");

    a_in_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_seen |=> !$isunknown(o_in_ready))
        else $error("input ready unknown after a request");

endmodule

bind triangle_tangent_basis ttb_props u_ttb_props (.*);
